// ===== sv/lccl_pkg.sv =====
// ----------------------------------------------------------------------------
// lccl_pkg
// Shared types and constants of the literate chunk line classifier.
// ----------------------------------------------------------------------------
package lccl_pkg;

  // Longest line kept before the rest of the stream is skipped
  localparam int unsigned MaxLine = 8191;
  localparam int unsigned CountW  = $clog2(MaxLine + 1);
  localparam int unsigned LenW    = 13;
  localparam int unsigned CountNumW = 32;

  // Character codes
  localparam logic [7:0] ChLt = 8'h3C;
  localparam logic [7:0] ChGt = 8'h3E;
  localparam logic [7:0] ChEq = 8'h3D;
  localparam logic [7:0] ChAt = 8'h40;
  localparam logic [7:0] ChSp = 8'h20;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  // Tail of a chunk start line: ">>="
  localparam logic [23:0] TailChunkOpen = {ChGt, ChGt, ChEq};

  typedef enum logic [1:0] {
    KindDoc        = 2'd0,
    KindChunkStart = 2'd1,
    KindChunkBody  = 2'd2,
    KindChunkEnd   = 2'd3
  } line_kind_e;

  // Line state seen by the classifier at a line end
  typedef struct packed {
    logic [CountW-1:0]    byte_count;
    logic [15:0]          head_bytes;
    logic [23:0]          tail_bytes;
    logic                 in_chunk;
    logic [CountNumW-1:0] chunk_counter;
  } line_state_t;

  // Classification of a closed line and the chunk state it leaves
  typedef struct packed {
    line_kind_e           kind;
    logic [CountNumW-1:0] chunk_number;
    logic                 payload_offset;
    logic                 in_chunk_next;
    logic [CountNumW-1:0] chunk_counter_next;
  } close_res_t;

  // One line record
  typedef struct packed {
    line_kind_e           kind;
    logic [CountNumW-1:0] chunk_number;
    logic [LenW-1:0]      line_bytes;
    logic                 payload_offset;
    logic [CountNumW-1:0] line_number;
    logic                 too_long;
  } line_rec_t;

endpackage

// ===== sv/literate_chunk_line_classifier.sv =====
// ----------------------------------------------------------------------------
// literate_chunk_line_classifier
// Splits a byte stream into lines and emits one classified record per line.
//
//  channel  dir  tdata                          tuser              tlast
//  s_axis   in   data_byte[7:0]                 -                  end_of_stream
//  m_axis   out  chunk_number, line_bytes,      line_kind,         -
//                payload_offset, line_number    too_long
//
// One byte is taken per cycle while tready is high; its record is registered
// in the output register, or in the skid register while the output register
// holds an untaken record; tready falls only when both hold a record. Reset
// clears all line and chunk state and empties this two-entry output stage.
// ----------------------------------------------------------------------------
module literate_chunk_line_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [31:0] chunk_number, [44:32] line_bytes,
                                        // [45] payload_offset, [77:46] line_number
  output logic [2:0]  m_axis_tuser_o    // [1:0] line_kind, [2] too_long
);
  import lccl_pkg::*;

  logic                 in_chunk_q, in_chunk_d;
  logic [CountNumW-1:0] chunk_counter_q, chunk_counter_d;
  logic [CountW-1:0]    byte_count_q, byte_count_d;
  logic [15:0]          head_bytes_q, head_bytes_d;
  logic [23:0]          tail_bytes_q, tail_bytes_d;
  logic                 pending_cr_q, pending_cr_d;
  logic                 skip_rest_q, skip_rest_d;
  logic [CountNumW-1:0] line_counter_q, line_counter_d;

  line_rec_t   out_q, skid_q, rec;
  logic        out_valid_q, skid_valid_q;
  logic        push, pop, accept, rec_valid;
  line_state_t cls_state;
  close_res_t  cls_res;
  logic [7:0]  b;
  logic [CountW+LenW-1:0] len_ext;
  logic [CountW+LenW-1:0] max_ext;
  logic [CountNumW-1:0]   line_inc;

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = out_valid_q && m_axis_tready_i;
  assign push            = accept && rec_valid;
  assign b               = s_axis_tdata_i;

  assign len_ext  = {{LenW{1'b0}}, byte_count_q};
  assign max_ext  = {{LenW{1'b0}}, CountW'(MaxLine)};
  assign line_inc = line_counter_q + CountNumW'(1);

  assign cls_state.byte_count    = byte_count_q;
  assign cls_state.head_bytes    = head_bytes_q;
  assign cls_state.tail_bytes    = tail_bytes_q;
  assign cls_state.in_chunk      = in_chunk_q;
  assign cls_state.chunk_counter = chunk_counter_q;

  lccl_line_close u_close (
    .state_i (cls_state),
    .res_o   (cls_res)
  );

  // Work out the next line state and the record of this transfer
  always_comb begin
    in_chunk_d      = in_chunk_q;
    chunk_counter_d = chunk_counter_q;
    byte_count_d    = byte_count_q;
    head_bytes_d    = head_bytes_q;
    tail_bytes_d    = tail_bytes_q;
    pending_cr_d    = pending_cr_q;
    skip_rest_d     = skip_rest_q;
    line_counter_d  = line_counter_q;
    rec_valid       = 1'b0;

    rec.kind           = cls_res.kind;
    rec.chunk_number   = cls_res.chunk_number;
    rec.line_bytes     = len_ext[LenW-1:0];
    rec.payload_offset = cls_res.payload_offset;
    rec.line_number    = line_inc;
    rec.too_long       = 1'b0;

    if (accept) begin
      if (s_axis_tlast_i) begin
        // Close an unterminated last line, then start a fresh stream
        if (!skip_rest_q && (byte_count_q != CountW'(0))) begin
          rec_valid       = 1'b1;
          in_chunk_d      = cls_res.in_chunk_next;
          chunk_counter_d = cls_res.chunk_counter_next;
        end
        byte_count_d   = '0;
        head_bytes_d   = '0;
        tail_bytes_d   = '0;
        pending_cr_d   = 1'b0;
        skip_rest_d    = 1'b0;
        line_counter_d = '0;
      end else if (!skip_rest_q) begin
        pending_cr_d = 1'b0;
        if (pending_cr_q && (b == ChLf)) begin
          // Swallow the LF of a CR LF pair
        end else if ((b == ChCr) || (b == ChLf)) begin
          rec_valid       = 1'b1;
          in_chunk_d      = cls_res.in_chunk_next;
          chunk_counter_d = cls_res.chunk_counter_next;
          line_counter_d  = line_inc;
          byte_count_d    = '0;
          head_bytes_d    = '0;
          tail_bytes_d    = '0;
          pending_cr_d    = (b == ChCr);
        end else if (byte_count_q >= CountW'(MaxLine)) begin
          // Line overflow: report it and skip the rest of the stream
          rec_valid          = 1'b1;
          rec.kind           = KindDoc;
          rec.chunk_number   = chunk_counter_q;
          rec.line_bytes     = max_ext[LenW-1:0];
          rec.payload_offset = 1'b0;
          rec.too_long       = 1'b1;
          line_counter_d     = line_inc;
          skip_rest_d        = 1'b1;
          byte_count_d       = '0;
          head_bytes_d       = '0;
          tail_bytes_d       = '0;
        end else begin
          // Append the byte
          if (byte_count_q == CountW'(0)) begin
            head_bytes_d = {b, 8'h00};
          end else if (byte_count_q == CountW'(1)) begin
            head_bytes_d = {head_bytes_q[15:8], b};
          end
          tail_bytes_d = {tail_bytes_q[15:0], b};
          byte_count_d = byte_count_q + CountW'(1);
        end
      end
    end
  end

  // Hold the line and chunk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_chunk_q      <= 1'b0;
      chunk_counter_q <= '0;
      byte_count_q    <= '0;
      head_bytes_q    <= '0;
      tail_bytes_q    <= '0;
      pending_cr_q    <= 1'b0;
      skip_rest_q     <= 1'b0;
      line_counter_q  <= '0;
    end else begin
      in_chunk_q      <= in_chunk_d;
      chunk_counter_q <= chunk_counter_d;
      byte_count_q    <= byte_count_d;
      head_bytes_q    <= head_bytes_d;
      tail_bytes_q    <= tail_bytes_d;
      pending_cr_q    <= pending_cr_d;
      skip_rest_q     <= skip_rest_d;
      line_counter_q  <= line_counter_d;
    end
  end

  // Advance the output register and skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (push && out_valid_q && !pop) begin
      skid_valid_q <= 1'b1;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load record payloads
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push && out_valid_q && !pop) begin
      skid_q <= rec;
    end else if (push) begin
      out_q <= rec;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.line_number, out_q.payload_offset,
                            out_q.line_bytes, out_q.chunk_number};
  assign m_axis_tuser_o  = {out_q.too_long, out_q.kind};

endmodule

// ===== sv/lccl_line_close.sv =====
// ----------------------------------------------------------------------------
// lccl_line_close
// Classifies a finished line as doc, chunk start, chunk body or chunk end and
// works out the chunk state it leaves behind.
// ----------------------------------------------------------------------------
module lccl_line_close (
  input  lccl_pkg::line_state_t state_i,
  output lccl_pkg::close_res_t  res_o
);
  import lccl_pkg::*;

  logic [7:0] h0;
  logic [7:0] h1;
  logic       is_start;
  logic       is_end;
  logic       n_ge2;

  assign h0    = state_i.head_bytes[15:8];
  assign h1    = state_i.head_bytes[7:0];
  assign n_ge2 = state_i.byte_count >= CountW'(2);

  // Match chunk start "<<...>>=" and chunk end "@" or "@ ..."
  assign is_start = (state_i.byte_count >= CountW'(6)) && (h0 == ChLt) && (h1 == ChLt)
                    && (state_i.tail_bytes == TailChunkOpen);
  assign is_end   = (h0 == ChAt)
                    && ((state_i.byte_count == CountW'(1)) || (n_ge2 && (h1 == ChSp)));

  // Pre-increment on a start, post-increment on an end
  always_comb begin
    res_o.kind               = KindDoc;
    res_o.chunk_number       = state_i.chunk_counter;
    res_o.payload_offset     = 1'b0;
    res_o.in_chunk_next      = state_i.in_chunk;
    res_o.chunk_counter_next = state_i.chunk_counter;
    if (is_start) begin
      res_o.kind               = KindChunkStart;
      res_o.chunk_number       = state_i.chunk_counter + CountNumW'(1);
      res_o.in_chunk_next      = 1'b1;
      res_o.chunk_counter_next = state_i.chunk_counter + CountNumW'(1);
    end else if (state_i.in_chunk) begin
      if (is_end) begin
        res_o.kind               = KindChunkEnd;
        res_o.in_chunk_next      = 1'b0;
        res_o.chunk_counter_next = state_i.chunk_counter + CountNumW'(1);
      end else begin
        res_o.kind           = KindChunkBody;
        res_o.payload_offset = n_ge2 && (h0 == ChAt) && (h1 == ChAt);
      end
    end
  end

endmodule
